// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for checker modules. They expect
// signals named clock and reset in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/msm_pkg.sv =====
// ----------------------------------------------------------------------------
// msm_pkg
// Types, register codes, reset values and the signature table of the
// multi-signature score matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

   localparam int unsigned NUM_SIGS    = 9;
   localparam int unsigned SIG_MAX_LEN = 18;
   localparam int unsigned SCORE_W     = 4;
   localparam int unsigned CFG_SIZE_W  = 30;
   localparam int unsigned CSR_IDX_W   = 2;

   // Signature text, right-aligned: the final character sits in byte 0.
   localparam logic [8*SIG_MAX_LEN-1:0] SIG_TEXT [NUM_SIGS] = '{
      (8*SIG_MAX_LEN)'("toggleUI"),
      (8*SIG_MAX_LEN)'("/getConfig"),
      (8*SIG_MAX_LEN)'("/saveConfig"),
      (8*SIG_MAX_LEN)'("hwidLogin"),
      (8*SIG_MAX_LEN)'({"rapid", "_fire"}),
      (8*SIG_MAX_LEN)'({"auto", "_click"}),
      (8*SIG_MAX_LEN)'("triggerbot"),
      (8*SIG_MAX_LEN)'({"no", "_recoil"}),
      (8*SIG_MAX_LEN)'("macros-unprotected")
   };

   localparam int unsigned SIG_LEN [NUM_SIGS] = '{8, 10, 11, 9, 10, 10, 10, 9, 18};

   localparam logic [SCORE_W-1:0]    RST_SCORE_THRESHOLD = SCORE_W'(2);
   localparam logic [CFG_SIZE_W-1:0] RST_MIN_FILE_SIZE   = CFG_SIZE_W'(10240);
   localparam logic [CFG_SIZE_W-1:0] RST_MAX_FILE_SIZE   = CFG_SIZE_W'(524288000);
   localparam logic [CFG_SIZE_W-1:0] RST_SCAN_LIMIT      = CFG_SIZE_W'(4194304);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_THRESHOLD = 2'd0,
      CSR_MIN_FILE_SIZE   = 2'd1,
      CSR_MAX_FILE_SIZE   = 2'd2,
      CSR_SCAN_LIMIT      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                  detected;
      logic                  size_rejected;
      logic [SCORE_W-1:0]    match_score;
      logic [NUM_SIGS-1:0]   found_mask;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/msm_sig_match.sv =====
// ----------------------------------------------------------------------------
// msm_sig_match
// Parallel compare of every signature against the current byte and the
// byte history; flags each signature that ends at the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_sig_match #(
   parameter int unsigned HIST_DEPTH = 17,
   parameter int unsigned FILL_W     = 5
) (
   input  wire logic [7:0]                  cur_byte,
   input  wire logic [7:0]                  hist [HIST_DEPTH],
   input  wire logic [FILL_W-1:0]           fill,
   output      logic [msm_pkg::NUM_SIGS-1:0] hit
);
   import msm_pkg::*;

   for (genvar s = 0; s < NUM_SIGS; s++) begin : g_sig
      localparam int unsigned LEN = SIG_LEN[s];
      if (LEN == 0 || LEN > HIST_DEPTH + 1) begin : g_never
         // too long for the window: never seen
         assign hit[s] = 1'b0;
      end else begin : g_cmp
         logic [LEN-1:0] eq;
         assign eq[0] = (cur_byte == SIG_TEXT[s][7:0]);
         for (genvar k = 0; k + 1 < LEN; k++) begin : g_hist
            assign eq[k+1] = (hist[k] == SIG_TEXT[s][8*(k+1) +: 8]);
         end
         assign hit[s] = (&eq) && (32'(fill) >= 32'(LEN - 1));
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/multi_signature_score_matcher_top.sv =====
// ----------------------------------------------------------------------------
// multi_signature_score_matcher_top
// Streams a file one byte per beat, marks fixed signature strings found
// within the scan limit and reports a score and detection flag per file.
// ----------------------------------------------------------------------------
// Takes one file byte per req beat (last_byte marks the final byte) and
// sustains one byte per clock: each byte is taken into an input register, and
// while it sits there all nine signature compares, the window shift, the
// saturating byte count and, for the last byte, the size check and score run
// together and land in registers at the next edge. The result beat is loaded
// into the result register at the edge that takes the last byte out of the input
// register and shows on rsp until taken; the only stall is a last byte that
// meets a result still held on rsp. Configuration writes are
// taken every cycle (csr_ready is tied high) and must be made while no file
// is in flight. There is no clearing pass after reset.
`default_nettype none

module multi_signature_score_matcher_top #(
   parameter int unsigned WINDOW_LEN = 18,
   parameter int unsigned COUNT_BITS = 30
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire msm_pkg::req_payload_type          req_payload,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      msm_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [msm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [msm_pkg::CFG_SIZE_W-1:0]    csr_data
);
   import msm_pkg::*;

   localparam int unsigned HIST_DEPTH = WINDOW_LEN - 1;
   localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);
   localparam int unsigned CMP_W      = (COUNT_BITS > CFG_SIZE_W) ? COUNT_BITS : CFG_SIZE_W;

   // configuration registers
   logic [SCORE_W-1:0]    threshold_ff;
   logic [CFG_SIZE_W-1:0] min_size_ff;
   logic [CFG_SIZE_W-1:0] max_size_ff;
   logic [CFG_SIZE_W-1:0] scan_limit_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // per-file state
   logic [7:0]            hist_ff [HIST_DEPTH];
   logic [7:0]            hist_in [HIST_DEPTH];
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [NUM_SIGS-1:0]   seen_ff, seen_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic                proc;
   logic                accept;
   logic                in_scan;
   logic                rejected;
   logic [NUM_SIGS-1:0] hit;
   logic [NUM_SIGS-1:0] mask;
   logic [SCORE_W-1:0]  score;
   logic [COUNT_BITS-1:0] count_next;

   // Process the held byte unless it is a last byte that would overwrite a
   // result still waiting on rsp.
   assign proc      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Compare every signature ending at the held byte, in parallel.
   msm_sig_match #(
      .HIST_DEPTH (HIST_DEPTH),
      .FILL_W     (FILL_W)
   ) u_match (
      .cur_byte (in_byte_ff),
      .hist     (hist_ff),
      .fill     (fill_ff),
      .hit      (hit)
   );

   always_comb begin
      // The byte's position is count + 1; it must not pass the scan limit.
      in_scan    = CMP_W'(count_ff) < CMP_W'(scan_limit_ff);
      count_next = (count_ff != '1) ? count_ff + COUNT_BITS'(1) : count_ff;
      seen_in    = in_scan ? (seen_ff | hit) : seen_ff;

      // Shift the window: the newest byte enters at slot 0.
      hist_in[0] = in_byte_ff;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
      fill_in  = (fill_ff < FILL_W'(HIST_DEPTH)) ? fill_ff + FILL_W'(1) : fill_ff;
      count_in = count_next;

      // End-of-file verdict from the updated state.
      rejected = (CMP_W'(count_next) < CMP_W'(min_size_ff)) ||
                 (CMP_W'(count_next) > CMP_W'(max_size_ff));
      mask     = rejected ? '0 : seen_in;
      score    = '0;
      for (int s = 0; s < NUM_SIGS; s++) begin
         score = score + SCORE_W'(mask[s]);
      end
      rsp_in.detected      = !rejected && (score >= threshold_ff);
      rsp_in.size_rejected = rejected;
      rsp_in.match_score   = score;
      rsp_in.found_mask    = mask;

      // Drop the per-file state after the last byte.
      if (in_last_ff) begin
         fill_in  = '0;
         seen_in  = '0;
         count_in = '0;
      end

      // Hold a result until taken; load a new one from the last byte.
      if (proc && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_ff       <= '0;
         seen_ff       <= '0;
         count_ff      <= '0;
         threshold_ff  <= RST_SCORE_THRESHOLD;
         min_size_ff   <= RST_MIN_FILE_SIZE;
         max_size_ff   <= RST_MAX_FILE_SIZE;
         scan_limit_ff <= RST_SCAN_LIMIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            fill_ff  <= fill_in;
            seen_ff  <= seen_in;
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SCORE_THRESHOLD: threshold_ff  <= csr_data[SCORE_W-1:0];
               CSR_MIN_FILE_SIZE:   min_size_ff   <= csr_data;
               CSR_MAX_FILE_SIZE:   max_size_ff   <= csr_data;
               CSR_SCAN_LIMIT:      scan_limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers: no reset, window bytes are gated by the fill count
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_payload.data_byte;
         in_last_ff <= req_payload.last_byte;
      end
      if (proc) begin
         hist_ff <= hist_in;
      end
      if (proc && in_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/msm_checker.sv =====
// ----------------------------------------------------------------------------
// msm_checker
// Port-level checks of the matcher's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msm_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire msm_pkg::rsp_payload_type rsp_payload
);
   import msm_pkg::*;

   logic found_none;
   logic score_matches;

   assign found_none    = !rsp_payload.detected && rsp_payload.match_score == '0 &&
                          rsp_payload.found_mask == '0;
   assign score_matches = 32'(rsp_payload.match_score) ==
                          32'($countones(rsp_payload.found_mask));

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // a file rejected by size is never detected and reports nothing found
   `ASSERT_IMPLIES(a_reject_clean, rsp_valid && rsp_payload.size_rejected, found_none)

   // the score is the number of signatures in the mask
   `ASSERT_IMPLIES(a_score_count, rsp_valid, score_matches)

   // a detected file always lies inside the size window
   `ASSERT_IMPLIES(a_detect_size, rsp_valid && rsp_payload.detected, !rsp_payload.size_rejected)

endmodule

bind multi_signature_score_matcher_top msm_checker u_msm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
